[hdl/hss_pkg.sv]
// Shared types, codes and the sine table builder for the harmonic series synthesizer.
package hss_pkg;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DC_OFFSET     = 2'd0;
  localparam cfg_idx_t CFG_FUND_STEP     = 2'd1;
  localparam cfg_idx_t CFG_FUND_AMPLITUDE = 2'd2;

  // Input item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  // Relative amplitude of 1.0 in Q1.16.
  localparam logic [16:0] AMP_ONE = 17'd65536;

  // Width of the shared multiplier's registered product.
  localparam int unsigned MUL_W = 48;

  // Two pi in Q3.30 for the Taylor series.
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] sample_time;
    logic [3:0]         harmonic_index;
    logic [16:0]        harmonic_amplitude;
    logic signed [15:0] harmonic_phase;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               saturated;
    logic               load_rejected;
  } out_t;

  // Restoring long division, used only while building constant tables.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One quarter-wave entry in unsigned Q1.15, evaluated at elaboration only.
  function automatic logic [15:0] sine_entry(int unsigned tb, int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] div;
    longint      sum;
    longint      r;
    x    = (64'(k) * TWO_PI_Q30) >> tb;
    term = x;
    sum  = longint'(x);
    for (int unsigned n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      div  = 64'((2 * n) * (2 * n + 1));
      term = div_u64(term, div);
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 64'sd16384) >>> 15;
    if (r > 32768) begin
      r = 32768;
    end
    return r[15:0];
  endfunction

endpackage

[hdl/harmonic_series_synthesizer.sv]
// Top level: sequencer, configuration registers and accumulator of the synthesizer.
//
// Usage: in_data_i carries one item per beat on a valid/ready channel. A load
// item (kind 1) writes one harmonic's relative amplitude and phase; a sample
// item (kind 0) produces one Q15.16 sample at the given tick. Every item
// gives exactly one result beat on out_data_o. Configuration registers are
// written through cfg_index_i / cfg_data_i, always ready; write them only
// while the block is idle.
// A load item goes through ST_DONE straight into the output register. A
// sample item runs one multiply for the base phase and one accumulator setup
// step, then, for each of the HARMONICS-1 terms, fundamental included, an
// amplitude scale and a sine product through the single shared multiplier and
// an accumulate step, then one rounding step and a move into the output
// register. One item is in work at a time; in_ready_o is low meanwhile, so
// the next item is taken only once the last result has entered the output
// register.
// A finished result sits in the output register; if the receiver stalls, the
// next item is still accepted and computed, and its result waits until the
// output register frees. Reset clears the configuration registers, the
// harmonic table (every entry reads as zero) and all handshake state.
module harmonic_series_synthesizer #(
  parameter int unsigned HARMONICS       = 16,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hss_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hss_pkg::out_t     out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  hss_pkg::cfg_idx_t cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import hss_pkg::*;

  localparam int unsigned HW    = $clog2(HARMONICS);
  localparam int unsigned ACC_W = 49 + $clog2(HARMONICS);
  localparam int unsigned RND_W = ACC_W - 15;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BASE = 3'd1;
  localparam logic [2:0] ST_PH   = 3'd2;
  localparam logic [2:0] ST_SCL  = 3'd3;
  localparam logic [2:0] ST_PRD  = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [31:0] dc_q;
  logic [31:0] step_q;
  logic [30:0] fa_q;

  logic [31:0] t_q, t_d;
  logic [31:0] base_q, base_d;
  logic [31:0] ph_acc_q, ph_acc_d;
  logic [HW-1:0] i_q, i_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  out_t res_q, res_d;
  out_t out_data_q;
  logic out_valid_q;

  logic in_fire;
  logic out_free;
  logic load_ok;
  logic [16:0] load_amp;

  logic [31:0] mul_a, mul_b;
  logic [MUL_W-1:0] mul_p;

  logic [HW-1:0] rd_addr;
  logic [16:0]   rd_amp;
  logic [15:0]   rd_phase;
  logic          first_harm;
  logic [16:0]   cur_amp;
  logic [15:0]   cur_phase;
  logic [31:0]   sine_phase;
  logic          sine_en;
  logic [15:0]   sine_mag;
  logic          sine_neg;

  logic [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W-1:0] rnd_sum;
  logic [RND_W-1:0]        rnd;
  logic [RND_W-32:0]       rnd_hi;
  logic                    ovf;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Loads are taken only for harmonics 2 .. HARMONICS-1.
  assign load_ok  = (32'(in_data_i.harmonic_index) >= 32'd2) &&
                    (32'(in_data_i.harmonic_index) < 32'(HARMONICS));
  assign load_amp = (in_data_i.harmonic_amplitude > AMP_ONE) ? AMP_ONE
                                                             : in_data_i.harmonic_amplitude;

  // The read address runs one step ahead so the data lines up with ST_SCL.
  assign rd_addr = (state_q == ST_ACC) ? (i_q + HW'(1)) : i_q;

  hss_harm_mem #(
    .HARMONICS(HARMONICS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_fire && (in_data_i.kind == KIND_LOAD) && load_ok),
    .wr_addr_i (HW'(in_data_i.harmonic_index)),
    .wr_amp_i  (load_amp),
    .wr_phase_i(in_data_i.harmonic_phase),
    .rd_addr_i (rd_addr),
    .rd_amp_o  (rd_amp),
    .rd_phase_o(rd_phase)
  );

  // The fundamental is handled as a harmonic of relative amplitude one and no phase.
  assign first_harm = (i_q == HW'(1));
  assign cur_amp    = first_harm ? AMP_ONE : rd_amp;
  assign cur_phase  = first_harm ? 16'd0 : rd_phase;
  assign sine_phase = ph_acc_q + {cur_phase, 16'd0};
  assign sine_en    = (state_q == ST_SCL);

  hss_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine (
    .clk_i  (clk_i),
    .en_i   (sine_en),
    .phase_i(sine_phase),
    .mag_o  (sine_mag),
    .neg_o  (sine_neg)
  );

  always_comb begin
    case (state_q)
      ST_BASE: begin
        mul_a = t_q;
        mul_b = step_q;
      end
      ST_SCL: begin
        mul_a = {1'b0, fa_q};
        mul_b = 32'(cur_amp);
      end
      ST_PRD: begin
        mul_a = mul_p[47:16];
        mul_b = 32'(sine_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  hss_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  assign prod_ext = {{(ACC_W-47){1'b0}}, mul_p[46:0]};

  // Round half up to Q.16, then clamp to the 32-bit range.
  assign rnd_sum = acc_q + ACC_W'(16384);
  assign rnd     = rnd_sum[ACC_W-1:15];
  assign rnd_hi  = rnd[RND_W-1:31];
  assign ovf     = !((&rnd_hi) || !(|rnd_hi));

  always_comb begin
    state_d  = state_q;
    t_d      = t_q;
    base_d   = base_q;
    ph_acc_d = ph_acc_q;
    i_d      = i_q;
    acc_d    = acc_q;
    res_d    = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.kind == KIND_LOAD) begin
            res_d.value         = '0;
            res_d.saturated     = 1'b0;
            res_d.load_rejected = !load_ok;
            state_d             = ST_DONE;
          end else begin
            t_d     = in_data_i.sample_time;
            i_d     = HW'(1);
            state_d = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        state_d = ST_PH;
      end
      ST_PH: begin
        base_d   = mul_p[31:0];
        ph_acc_d = mul_p[31:0];
        acc_d    = {{(ACC_W-47){dc_q[31]}}, dc_q, 15'd0};
        state_d  = ST_SCL;
      end
      ST_SCL: begin
        state_d = ST_PRD;
      end
      ST_PRD: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d    = sine_neg ? (acc_q - prod_ext) : (acc_q + prod_ext);
        ph_acc_d = ph_acc_q + base_q;
        i_d      = i_q + HW'(1);
        state_d  = (i_q == HW'(HARMONICS - 1)) ? ST_FIN : ST_SCL;
      end
      ST_FIN: begin
        res_d.saturated     = ovf;
        res_d.load_rejected = 1'b0;
        if (ovf) begin
          res_d.value = rnd[RND_W-1] ? VALUE_MIN : VALUE_MAX;
        end else begin
          res_d.value = rnd[31:0];
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dc_q        <= '0;
      step_q      <= '0;
      fa_q        <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DC_OFFSET:      dc_q   <= cfg_data_i;
          CFG_FUND_STEP:      step_q <= cfg_data_i;
          CFG_FUND_AMPLITUDE: fa_q   <= cfg_data_i[30:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    base_q   <= base_d;
    ph_acc_q <= ph_acc_d;
    i_q      <= i_d;
    acc_q    <= acc_d;
    res_q    <= res_d;
    if ((state_q == ST_DONE) && out_free) begin
      out_data_q <= res_q;
    end
  end

endmodule

[hdl/hss_mul.sv]
// Shared unsigned 32 by 32 multiplier with a registered product.
module hss_mul (
  input  logic                      clk_i,
  input  logic [31:0]               a_i,
  input  logic [31:0]               b_i,
  output logic [hss_pkg::MUL_W-1:0] p_o
);
  import hss_pkg::*;

  logic [63:0]      full;
  logic [MUL_W-1:0] p_q;

  assign full = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= full[MUL_W-1:0];
  end

  assign p_o = p_q;

endmodule

[hdl/hss_sine_rom.sv]
// Quarter-wave sine ROM with quadrant folding and a registered read.
module hss_sine_rom #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] phase_i,
  output logic [15:0] mag_o,
  output logic        neg_o
);
  import hss_pkg::*;

  localparam int unsigned QLEN = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned AW   = SINE_TABLE_BITS - 1;

  typedef logic [15:0] rom_t [QLEN+1];

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned k = 0; k <= QLEN; k++) begin
      t[k] = sine_entry(SINE_TABLE_BITS, k);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-3:0] j;
  logic [AW-1:0]              addr;
  logic [15:0]                mag_q;
  logic                       neg_q;

  assign idx  = phase_i[31 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign j    = idx[SINE_TABLE_BITS-3:0];
  // Odd quadrants run the table backward; the upper half is negated.
  assign addr = quad[0] ? (AW'(QLEN) - AW'(j)) : AW'(j);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= ROM[addr];
      neg_q <= quad[1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

[hdl/hss_harm_mem.sv]
// Harmonic amplitude and phase memory with per-entry valid bits.
module hss_harm_mem #(
  parameter int unsigned HARMONICS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [$clog2(HARMONICS)-1:0] wr_addr_i,
  input  logic [16:0]                  wr_amp_i,
  input  logic [15:0]                  wr_phase_i,
  input  logic [$clog2(HARMONICS)-1:0] rd_addr_i,
  output logic [16:0]                  rd_amp_o,
  output logic [15:0]                  rd_phase_o
);
  import hss_pkg::*;

  logic [16:0]          amp_mem   [HARMONICS];
  logic [15:0]          phase_mem [HARMONICS];
  logic [HARMONICS-1:0] valid_q;
  logic [16:0]          rd_amp_q;
  logic [15:0]          rd_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      amp_mem[wr_addr_i]   <= wr_amp_i;
      phase_mem[wr_addr_i] <= wr_phase_i;
    end
  end

  // An entry never loaded since reset reads as zero.
  always_ff @(posedge clk_i) begin
    if (valid_q[rd_addr_i]) begin
      rd_amp_q   <= amp_mem[rd_addr_i];
      rd_phase_q <= phase_mem[rd_addr_i];
    end else begin
      rd_amp_q   <= '0;
      rd_phase_q <= '0;
    end
  end

  assign rd_amp_o   = rd_amp_q;
  assign rd_phase_o = rd_phase_q;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the harmonic series synthesizer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hss_pkg::*;

  localparam int unsigned HARMONICS   = 16;
  localparam int unsigned SINE_BITS   = 10;
  localparam int unsigned QUARTER_LEN = 1 << (SINE_BITS - 2);
  localparam int unsigned SAMPLE_CYCLES = 3 * HARMONICS + 3;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned MAX_REPORTS   = 10;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  in_t      in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_t     out_data_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  cfg_idx_t cfg_index_i = CFG_DC_OFFSET;
  logic [31:0] cfg_data_i = '0;

  harmonic_series_synthesizer #(
    .HARMONICS      (HARMONICS),
    .SINE_TABLE_BITS(SINE_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: configuration, harmonic table and the sine quarter wave.
  logic signed [31:0] dc_reg;
  logic [31:0]        step_reg;
  logic [30:0]        fund_amp_reg;
  logic [16:0]        harm_amp [HARMONICS];
  logic [15:0]        harm_phase [HARMONICS];
  logic [15:0]        quarter_wave [QUARTER_LEN + 1];

  out_t pending_results[$];
  out_t want_result;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_request;
  int stall_left;
  int unsigned cycle_count;
  int mismatch_count;
  int n_samples;
  int n_loads;
  int n_rejected;
  int n_saturated;
  int n_cfg_writes;
  int n_checked;

  function automatic void build_quarter_wave();
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    longint          r;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      x    = (64'(k) * TWO_PI_Q30) >> SINE_BITS;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      r = (acc + 16384) >>> 15;
      if (r > 32768) begin
        r = 32768;
      end
      quarter_wave[k] = r[15:0];
    end
  endfunction

  // The top bits of the phase pick the quadrant and the table position.
  function automatic int sine_lookup(logic [31:0] phase);
    logic [SINE_BITS-1:0] idx;
    logic [SINE_BITS-3:0] pos;
    int                   mag;
    idx = phase[31 -: SINE_BITS];
    pos = idx[SINE_BITS-3:0];
    if (idx[SINE_BITS-2]) begin
      mag = int'(quarter_wave[QUARTER_LEN - pos]);
    end else begin
      mag = int'(quarter_wave[pos]);
    end
    return idx[SINE_BITS-1] ? -mag : mag;
  endfunction

  function automatic out_t synth_result(in_t item);
    out_t        res;
    logic [31:0] base;
    logic [31:0] ph;
    logic [16:0] amp;
    longint      acc;
    longint      scaled;
    res = '0;
    if (item.kind == KIND_LOAD) begin
      n_loads++;
      if (item.harmonic_index < 2 || item.harmonic_index >= HARMONICS) begin
        res.load_rejected = 1'b1;
        n_rejected++;
      end else begin
        amp = (item.harmonic_amplitude > AMP_ONE) ? AMP_ONE : item.harmonic_amplitude;
        harm_amp[item.harmonic_index]   = amp;
        harm_phase[item.harmonic_index] = item.harmonic_phase;
      end
      return res;
    end
    n_samples++;
    base = item.sample_time * step_reg;
    acc  = longint'(dc_reg) * 32768;
    acc  = acc + longint'({33'd0, fund_amp_reg}) * sine_lookup(base);
    for (int i = 2; i < HARMONICS; i++) begin
      scaled = longint'(({33'd0, fund_amp_reg} * {47'd0, harm_amp[i]}) >> 16);
      ph     = 32'(i) * base + {harm_phase[i], 16'h0000};
      acc    = acc + scaled * sine_lookup(ph);
    end
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > longint'(VALUE_MAX)) begin
      acc = longint'(VALUE_MAX);
      res.saturated = 1'b1;
    end else if (acc < longint'(VALUE_MIN)) begin
      acc = longint'(VALUE_MIN);
      res.saturated = 1'b1;
    end
    if (res.saturated) begin
      n_saturated++;
    end
    res.value = acc[31:0];
    return res;
  endfunction

  function automatic in_t make_item(logic kind, logic [31:0] t, logic [3:0] idx,
                                    logic [16:0] amp, logic [15:0] ph);
    in_t it;
    it.kind               = kind;
    it.sample_time        = t;
    it.harmonic_index     = idx;
    it.harmonic_amplitude = amp;
    it.harmonic_phase     = ph;
    return it;
  endfunction

  function automatic in_t random_item();
    logic [31:0] t;
    logic [16:0] amp;
    t   = ($urandom_range(3) == 0) ? 32'($urandom_range(200) - 100) : $urandom;
    amp = ($urandom_range(4) == 0) ? 17'($urandom) : 17'($urandom_range(AMP_ONE));
    return make_item(($urandom_range(99) < 20) ? KIND_LOAD : KIND_SAMPLE, t,
                     4'($urandom), amp, 16'($urandom));
  endfunction

  task automatic report_failure(string what, out_t want, out_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected value=%h sat=%b rej=%b, got value=%h sat=%b rej=%b",
               $realtime, what, want.value, want.saturated, want.load_rejected,
               got.value, got.saturated, got.load_rejected);
    end
  endtask

  // Result checker: every accepted output beat is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_failure("unexpected result beat", '0, out_data_o);
      end else begin
        want_result = pending_results.pop_front();
        n_checked++;
        if (out_data_o.value !== want_result.value) begin
          report_failure("value mismatch", want_result, out_data_o);
        end
        if (out_data_o.saturated !== want_result.saturated) begin
          report_failure("saturated mismatch", want_result, out_data_o);
        end
        if (out_data_o.load_rejected !== want_result.load_rejected) begin
          report_failure("load_rejected mismatch", want_result, out_data_o);
        end
      end
    end
  end

  // Output side: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk_i) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left  = stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(in_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(synth_result(item));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DC_OFFSET: begin
        dc_reg = data;
      end
      CFG_FUND_STEP: begin
        step_reg = data;
      end
      CFG_FUND_AMPLITUDE: begin
        fund_amp_reg = data[30:0];
      end
      default: begin
      end
    endcase
    n_cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [31:0] dc, logic [31:0] step, logic [31:0] amp);
    wait_idle();
    cfg_write(CFG_DC_OFFSET, dc);
    cfg_write(CFG_FUND_STEP, step);
    cfg_write(CFG_FUND_AMPLITUDE, amp);
  endtask

  task automatic test_directed();
    set_config(32'h0, 32'h0100_0000, 32'h0001_0000);
    send_item(make_item(KIND_SAMPLE, 32'h0000_0000, 4'd0, 17'd0, 16'h0));
    send_item(make_item(KIND_SAMPLE, 32'h0000_0001, 4'd0, 17'd0, 16'h0));
    send_item(make_item(KIND_SAMPLE, 32'h7fff_ffff, 4'd0, 17'd0, 16'h0));
    send_item(make_item(KIND_SAMPLE, 32'h8000_0000, 4'd0, 17'd0, 16'h0));
    send_item(make_item(KIND_SAMPLE, 32'hffff_ffff, 4'd0, 17'd0, 16'h0));
    // Indexes 0 and 1 are refused and must leave the table untouched.
    send_item(make_item(KIND_LOAD, 32'h0, 4'd0, AMP_ONE, 16'h4000));
    send_item(make_item(KIND_LOAD, 32'h0, 4'd1, AMP_ONE, 16'h4000));
    send_item(make_item(KIND_LOAD, 32'h0, 4'd2, AMP_ONE, 16'h0000));
    send_item(make_item(KIND_LOAD, 32'hffff_ffff, 4'd15, 17'h1ffff, 16'h8000));
    send_item(make_item(KIND_LOAD, 32'h0, 4'd7, 17'd65537, 16'h7fff));
    send_item(make_item(KIND_LOAD, 32'h0, 4'd3, 17'd0, 16'h4000));
    send_item(make_item(KIND_SAMPLE, 32'd5, 4'hf, 17'h1ffff, 16'hffff));
    send_item(make_item(KIND_SAMPLE, -32'sd77, 4'd0, 17'd0, 16'h0));
    send_item(make_item(KIND_SAMPLE, 32'd123456, 4'd0, 17'd0, 16'h0));
    send_item(make_item(KIND_LOAD, 32'h0, 4'd2, 17'd32768, 16'hc000));
    send_item(make_item(KIND_SAMPLE, 32'd3, 4'd0, 17'd0, 16'h0));
  endtask

  task automatic test_saturation_and_extremes();
    // A quarter-turn phase on harmonic 2 puts its sine at full scale for any time at step 0.
    set_config(VALUE_MAX, 32'h0, 32'hffff_ffff);
    send_item(make_item(KIND_LOAD, 32'h0, 4'd2, AMP_ONE, 16'h4000));
    send_item(make_item(KIND_SAMPLE, 32'h0, 4'd0, 17'd0, 16'h0));
    set_config(VALUE_MIN, 32'h0, 32'h7fff_ffff);
    send_item(make_item(KIND_LOAD, 32'h0, 4'd2, AMP_ONE, 16'hc000));
    send_item(make_item(KIND_SAMPLE, 32'h1234_5678, 4'd0, 17'd0, 16'h0));
    set_config(VALUE_MIN, 32'hffff_ffff, 32'h0);
    send_item(make_item(KIND_SAMPLE, 32'h7fff_ffff, 4'd0, 17'd0, 16'h0));
    set_config(32'h0, 32'h4000_0000, 32'h7fff_ffff);
    send_item(make_item(KIND_SAMPLE, 32'h1, 4'd0, 17'd0, 16'h0));
    send_item(make_item(KIND_SAMPLE, 32'h3, 4'd0, 17'd0, 16'h0));
    set_config(32'h0, 32'h0, 32'h0);
    send_item(make_item(KIND_SAMPLE, 32'hdead_beef, 4'd0, 17'd0, 16'h0));
  endtask

  task automatic test_random(int n_items, int send_pct, int recv_pct);
    logic [31:0] r;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 58 == 0) begin
        r = $urandom;
        set_config(($urandom_range(3) == 0) ? $urandom : {{12{r[19]}}, r[19:0]},
                   ($urandom_range(3) == 0) ? 32'($urandom_range(1000)) : $urandom,
                   ($urandom_range(4) == 0) ? $urandom : 32'($urandom_range(32'h0003_0000)));
      end
      send_item(random_item());
    end
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 400;
    for (int i = 0; i < 12; i++) begin
      send_item(random_item());
    end
  endtask

  initial begin
    build_quarter_wave();
    dc_reg       = '0;
    step_reg     = '0;
    fund_amp_reg = '0;
    for (int i = 0; i < HARMONICS; i++) begin
      harm_amp[i]   = '0;
      harm_phase[i] = '0;
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_saturation_and_extremes();
    test_random(290, 18, 57);
    test_random(290, 57, 18);
    test_random(290, 0, 0);
    test_output_backpressure();

    wait_idle();
    repeat (SAMPLE_CYCLES + 10) @(posedge clk_i);
    $display("Covered %0d sample beats (%0d clamped) and %0d table loads (%0d refused)",
             n_samples, n_saturated, n_loads, n_rejected);
    $display("over %0d register writes; %0d results checked, %0d mismatches",
             n_cfg_writes, n_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[harmonic_series_synthesizer.f]
hdl/hss_pkg.sv
hdl/hss_mul.sv
hdl/hss_sine_rom.sv
hdl/hss_harm_mem.sv
hdl/harmonic_series_synthesizer.sv
tb/sv/tb_top.sv
